>>> sv/epp_pkg.sv
// Shared types, fixed widths and elaboration-time CORDIC constants for the
// ellipse polygon point unit. No dependencies.
package epp_pkg;

  localparam int COORD_W   = 16;
  localparam int RADIUS_W  = 15;
  localparam int COUNT_W   = 7;
  localparam int TRIG_FRAC = 16;
  localparam int TRIG_W    = TRIG_FRAC + 2;
  localparam int FRAC_W    = 48;
  localparam int XY_W      = FRAC_W + 2;
  localparam int ZFRAC_W   = 56;
  localparam int Z_W       = ZFRAC_W + 1;
  localparam int ITERS     = 44;
  localparam int ITER_W    = $clog2(ITERS);

  localparam real TURN_PER_RAD = 0.15915494309189535;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic [RADIUS_W-1:0]       radius_x;
    logic [RADIUS_W-1:0]       radius_y;
    logic [COUNT_W-1:0]        point_count;
  } epp_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      last_point;
  } epp_out_t;

  typedef logic [Z_W-1:0] atan_tab_t [ITERS];

  function automatic atan_tab_t atan_table();
    atan_tab_t tab;
    real       a;
    for (int i = 0; i < ITERS; i++) begin
      a = $atan(2.0 ** (-i)) * TURN_PER_RAD * (2.0 ** ZFRAC_W);
      tab[i] = Z_W'(longint'(a));
    end
    return tab;
  endfunction

  function automatic logic signed [XY_W-1:0] cordic_x0();
    real inv_k;
    inv_k = 1.0;
    for (int i = 0; i < ITERS; i++) begin
      inv_k = inv_k * ((1.0 + 2.0 ** (-2 * i)) ** (-0.5));
    end
    return XY_W'(longint'(inv_k * (2.0 ** FRAC_W)));
  endfunction

endpackage

>>> sv/epp_div.sv
// Bit-serial restoring divider: phase = floor(index * 2^PHASE_BITS / count).
// One quotient bit per cycle. No package dependencies.
module epp_div #(
  parameter int PHASE_BITS = 16,
  parameter int CNT_W      = 7,
  parameter int IDX_W      = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [IDX_W-1:0]      index,
  input  logic [CNT_W-1:0]      count,
  output logic                  done,
  output logic [PHASE_BITS-1:0] phase
);

  localparam int BIT_W = $clog2(PHASE_BITS + 1);

  logic                  busy_r;
  logic                  done_r;
  logic [BIT_W-1:0]      bit_cnt_r;
  logic [CNT_W-1:0]      rem_r;
  logic [CNT_W-1:0]      div_r;
  logic [PHASE_BITS-1:0] quo_r;
  logic [CNT_W:0]        rem_sh;
  logic [CNT_W:0]        rem_sub;
  logic                  take;

  always_comb begin
    rem_sh  = {rem_r, 1'b0};
    rem_sub = rem_sh - {1'b0, div_r};
    take    = rem_sh >= {1'b0, div_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      done_r    <= 1'b0;
      bit_cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r    <= 1'b1;
        bit_cnt_r <= BIT_W'(PHASE_BITS);
      end else if (busy_r) begin
        bit_cnt_r <= bit_cnt_r - BIT_W'(1);
        if (bit_cnt_r == BIT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= CNT_W'(index);
      div_r <= count;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= take ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      quo_r <= {quo_r[PHASE_BITS-2:0], take};
    end
  end

  assign done  = done_r;
  assign phase = quo_r;

endmodule

>>> sv/epp_cordic.sv
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, angle in turns.
// Depends on epp_pkg for widths, arctangent table and gain constant.
module epp_cordic (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [epp_pkg::Z_W-1:0]           angle,
  output logic                              done,
  output logic signed [epp_pkg::TRIG_W-1:0] cos_q,
  output logic signed [epp_pkg::TRIG_W-1:0] sin_q
);

  import epp_pkg::*;

  localparam atan_tab_t                ATAN   = atan_table();
  localparam logic signed [XY_W-1:0]   X_INIT = cordic_x0();
  localparam logic signed [XY_W-1:0]   RND    = XY_W'(1) << (FRAC_W - TRIG_FRAC - 1);

  logic                   busy_r;
  logic                   done_r;
  logic [ITER_W-1:0]      it_r;
  logic signed [XY_W-1:0] x_r;
  logic signed [XY_W-1:0] y_r;
  logic signed [Z_W-1:0]  z_r;
  logic signed [XY_W-1:0] x_sh;
  logic signed [XY_W-1:0] y_sh;
  logic signed [XY_W-1:0] x_nxt;
  logic signed [XY_W-1:0] y_nxt;
  logic signed [Z_W-1:0]  z_nxt;
  logic signed [XY_W-1:0] x_rnd;
  logic signed [XY_W-1:0] y_rnd;

  always_comb begin
    x_sh = x_r >>> it_r;
    y_sh = y_r >>> it_r;
    if (z_r[Z_W-1]) begin
      x_nxt = x_r + y_sh;
      y_nxt = y_r - x_sh;
      z_nxt = z_r + $signed(ATAN[it_r]);
    end else begin
      x_nxt = x_r - y_sh;
      y_nxt = y_r + x_sh;
      z_nxt = z_r - $signed(ATAN[it_r]);
    end
    x_rnd = x_r + RND;
    y_rnd = y_r + RND;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        it_r   <= '0;
      end else if (busy_r) begin
        if (it_r == ITER_W'(ITERS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          it_r <= it_r + ITER_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= X_INIT;
      y_r <= '0;
      z_r <= $signed(angle);
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign done  = done_r;
  assign cos_q = x_rnd[FRAC_W-TRIG_FRAC +: TRIG_W];
  assign sin_q = y_rnd[FRAC_W-TRIG_FRAC +: TRIG_W];

endmodule

>>> sv/epp_coord.sv
// Shared coordinate unit: radius * trig + center, truncated toward zero and
// saturated, one coordinate per enabled cycle. Depends on epp_pkg.
module epp_coord (
  input  logic                               clk,
  input  logic                               en,
  input  logic [epp_pkg::RADIUS_W-1:0]       radius,
  input  logic signed [epp_pkg::TRIG_W-1:0]  trig,
  input  logic signed [epp_pkg::COORD_W-1:0] center,
  output logic signed [epp_pkg::COORD_W-1:0] result
);

  import epp_pkg::*;

  localparam int PROD_W = RADIUS_W + 1 + TRIG_W;
  localparam int Q_W    = PROD_W - TRIG_FRAC;
  localparam logic signed [Q_W-1:0] SAT_HI = Q_W'(2 ** (COORD_W - 1) - 1);
  localparam logic signed [Q_W-1:0] SAT_LO = Q_W'(-(2 ** (COORD_W - 1)));

  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  sum;
  logic signed [Q_W-1:0]     quo;
  logic signed [Q_W-1:0]     quo_t;
  logic signed [COORD_W-1:0] sat;
  logic signed [COORD_W-1:0] result_r;

  always_comb begin
    prod = $signed({1'b0, radius}) * trig;
    sum  = prod + $signed({{(PROD_W - COORD_W - TRIG_FRAC){center[COORD_W-1]}},
                           center, {TRIG_FRAC{1'b0}}});
    quo  = sum[PROD_W-1:TRIG_FRAC];
    if (sum[PROD_W-1] && (sum[TRIG_FRAC-1:0] != '0)) begin
      quo_t = quo + Q_W'(1);
    end else begin
      quo_t = quo;
    end
    if (quo_t > SAT_HI) begin
      sat = SAT_HI[COORD_W-1:0];
    end else if (quo_t < SAT_LO) begin
      sat = SAT_LO[COORD_W-1:0];
    end else begin
      sat = quo_t[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_r <= sat;
    end
  end

  assign result = result_r;

endmodule

>>> sv/ellipse_polygon_points_unit.sv
// Ellipse polygon point unit: sequencer over phase divider, CORDIC and coordinate unit.
// Depends on epp_pkg, epp_div, epp_cordic and epp_coord.
// Per vertex: PHASE_BITS-bit phase divide, 44 CORDIC iterations, then x and y through the
// shared coordinate unit before the vertex is offered on the output.
// No new request is taken until the last vertex transaction completes.
// Synchronous active-low reset clears the sequencer; no clearing pass.
module ellipse_polygon_points_unit #(
  parameter int MAX_POINTS = 64,
  parameter int PHASE_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  epp_pkg::epp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output epp_pkg::epp_out_t out_data
);

  import epp_pkg::*;

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int R_W   = PHASE_BITS - 2;

  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;
  localparam logic [1:0] QUAD_IV  = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DIV   = 5'b00010,
    ST_TRIG  = 5'b00100,
    ST_COORD = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [IDX_W-1:0]          idx_r, idx_nxt;
  logic [CNT_W-1:0]          count_r;
  logic                      sel_r, sel_nxt;
  logic signed [COORD_W-1:0] cx_r, cy_r;
  logic [RADIUS_W-1:0]       rx_r, ry_r;
  logic [1:0]                quad_r;
  logic                      swap_r;
  logic signed [TRIG_W-1:0]  cq_r, sq_r;
  logic signed [COORD_W-1:0] px_r;

  logic                      accept;
  logic                      is_last;
  logic [CNT_W-1:0]          count_in;
  logic                      div_start, div_done;
  logic [CNT_W-1:0]          div_count;
  logic [PHASE_BITS-1:0]     div_phase;
  logic [R_W-1:0]            r_raw, r_oct;
  logic                      r_swap;
  logic [Z_W-1:0]            angle;
  logic                      cordic_start, cordic_done;
  logic signed [TRIG_W-1:0]  cordic_cos, cordic_sin;
  logic signed [TRIG_W-1:0]  c_oct, s_oct, cq_nxt, sq_nxt;
  logic                      coord_en;
  logic [RADIUS_W-1:0]       coord_radius;
  logic signed [TRIG_W-1:0]  coord_trig;
  logic signed [COORD_W-1:0] coord_center, coord_res;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign is_last  = (CNT_W'(idx_r) + CNT_W'(1)) == count_r;
  assign count_in = (in_data.point_count > COUNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                                  : CNT_W'(in_data.point_count);

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    sel_nxt      = sel_r;
    div_start    = 1'b0;
    cordic_start = 1'b0;
    coord_en     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept && (count_in != '0)) begin
          state_nxt = ST_DIV;
          idx_nxt   = '0;
          div_start = 1'b1;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          cordic_start = 1'b1;
          state_nxt    = ST_TRIG;
        end
      end
      ST_TRIG: begin
        if (cordic_done) begin
          sel_nxt   = 1'b0;
          state_nxt = ST_COORD;
        end
      end
      ST_COORD: begin
        coord_en = 1'b1;
        sel_nxt  = 1'b1;
        if (sel_r) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          if (is_last) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign div_count = (state_r == ST_IDLE) ? count_in : count_r;

  // fold the phase into the first octant
  always_comb begin
    r_raw  = div_phase[R_W-1:0];
    r_swap = r_raw > (R_W'(1) << (R_W - 1));
    r_oct  = r_swap ? R_W'({1'b1, {R_W{1'b0}}} - {1'b0, r_raw}) : r_raw;
    angle  = Z_W'(r_oct) << (ZFRAC_W - PHASE_BITS);
  end

  always_comb begin
    c_oct = swap_r ? cordic_sin : cordic_cos;
    s_oct = swap_r ? cordic_cos : cordic_sin;
    case (quad_r)
      QUAD_I: begin
        cq_nxt = c_oct;
        sq_nxt = s_oct;
      end
      QUAD_II: begin
        cq_nxt = -s_oct;
        sq_nxt = c_oct;
      end
      QUAD_III: begin
        cq_nxt = -c_oct;
        sq_nxt = -s_oct;
      end
      QUAD_IV: begin
        cq_nxt = s_oct;
        sq_nxt = -c_oct;
      end
      default: begin
        cq_nxt = c_oct;
        sq_nxt = s_oct;
      end
    endcase
  end

  always_comb begin
    coord_radius = sel_r ? ry_r : rx_r;
    coord_trig   = sel_r ? sq_r : cq_r;
    coord_center = sel_r ? cy_r : cx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      count_r <= '0;
      sel_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      sel_r   <= sel_nxt;
      if (accept) begin
        count_r <= count_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cx_r <= in_data.center_x;
      cy_r <= in_data.center_y;
      rx_r <= in_data.radius_x;
      ry_r <= in_data.radius_y;
    end
    if ((state_r == ST_DIV) && div_done) begin
      quad_r <= div_phase[PHASE_BITS-1 -: 2];
      swap_r <= r_swap;
    end
    if ((state_r == ST_TRIG) && cordic_done) begin
      cq_r <= cq_nxt;
      sq_r <= sq_nxt;
    end
    if ((state_r == ST_COORD) && sel_r) begin
      px_r <= coord_res;
    end
  end

  epp_div #(
    .PHASE_BITS (PHASE_BITS),
    .CNT_W      (CNT_W),
    .IDX_W      (IDX_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .index (idx_nxt),
    .count (div_count),
    .done  (div_done),
    .phase (div_phase)
  );

  epp_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .angle (angle),
    .done  (cordic_done),
    .cos_q (cordic_cos),
    .sin_q (cordic_sin)
  );

  epp_coord u_coord (
    .clk    (clk),
    .en     (coord_en),
    .radius (coord_radius),
    .trig   (coord_trig),
    .center (coord_center),
    .result (coord_res)
  );

  assign out_valid           = (state_r == ST_OUT);
  assign out_data.point_x    = px_r;
  assign out_data.point_y    = coord_res;
  assign out_data.last_point = is_last;

  a_accept_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> !out_valid)
    else $error("request transaction accepted while a vertex is pending");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (CNT_W'(idx_r) < count_r))
    else $error("vertex index beyond held count");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_data.last_point) |=> !in_stall)
    else $error("not ready after final vertex transaction");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("phase divider finished outside divide state");

  a_cordic_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    cordic_done |-> (state_r == ST_TRIG))
    else $error("rotation unit finished outside trig state");

endmodule
